// ===== hw/rtl/ggsq_pkg.sv =====
package ggsq_pkg;

   localparam int unsigned RegW     = 15;
   localparam int unsigned MaskW    = 12;
   localparam int unsigned SpanW    = 7;
   localparam int unsigned CsrIdxW  = 3;
   localparam int unsigned CsrDataW = 8;

   localparam logic [CsrIdxW-1:0] CSR_ROOT_NOTE   = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_OCTAVE_SPAN = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_GATE_ON     = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_GATE_OFF    = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_ACCENT      = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_RHYTHM_LOCK = 3'd5;
   localparam logic [CsrIdxW-1:0] CSR_LEVEL_SHIFT = 3'd6;

   localparam logic [RegW-1:0] LEVEL4_LIMIT = 15'd26214;
   localparam logic [RegW-1:0] LEVEL3_LIMIT = 15'd19660;
   localparam logic [RegW-1:0] LEVEL2_LIMIT = 15'd13107;
   localparam logic [RegW-1:0] LEVEL1_LIMIT = 15'd6553;

   localparam logic [3:0] SEMITONES     = 4'd12;
   localparam logic [3:0] LAST_SEMITONE = 4'd11;
   localparam logic [6:0] RECIP12       = 7'd43;

   typedef enum logic [4:0] {
      SNAP_IDLE   = 5'b00001,
      SNAP_MUL    = 5'b00010,
      SNAP_MOD    = 5'b00100,
      SNAP_SEARCH = 5'b01000,
      SNAP_DONE   = 5'b10000
   } snap_state_type;

   typedef struct packed {
      logic idle;
      logic done;
   } snap_stat_type;

   function automatic logic [MaskW-1:0] scale_mask(input logic [2:0] lvl);
      logic [MaskW-1:0] m;
      case (lvl)
         3'd0: m = 12'h0FFF;
         3'd1: m = 12'h06DB;
         3'd2: m = 12'h09AD;
         3'd3: m = 12'h0AB5;
         3'd4: m = 12'h0295;
         default: m = 12'h0295;
      endcase
      return m;
   endfunction

endpackage

// ===== hw/rtl/gradient_gate_scale_quantizer_unit.sv =====
// an accepted transaction passes the step unit states mul, mod, search and done, then loads
// the result register; the nearest-semitone search of the step unit takes one to twelve steps
// one transaction in the step unit at a time; req_stall is high until it returns to idle
// reset: synchronous; registers return to their defaults, gate, history and tick
// counter clear, and the result register empties
module gradient_gate_scale_quantizer_unit
   import ggsq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_raw_value,
   input  logic [7:0]          req_depth_feature,
   input  logic [7:0]          req_strength_feature,
   input  logic [RegW-1:0]     req_regularity,
   input  logic [4:0]          req_pos_x,
   input  logic [4:0]          req_pos_y,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [31:0]         rsp_step_count,
   output logic [4:0]          rsp_out_x,
   output logic [4:0]          rsp_out_y,
   output logic [7:0]          rsp_note,
   output logic                rsp_gate_out,
   output logic                rsp_note_on,
   output logic                rsp_accent,
   output logic [7:0]          rsp_strength_out,
   output logic [7:0]          rsp_regularity_out,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   logic [6:0]  root_ff;
   logic [3:0]  octave_ff;
   logic [7:0]  gate_on_ff;
   logic [7:0]  gate_off_ff;
   logic [7:0]  accent_thr_ff;
   logic        lock_ff;
   logic [3:0]  bias_ff;

   logic        gate_ff, gate_in;
   logic [7:0]  last_raw_ff;
   logic        last_valid_ff;
   logic [31:0] step_ff;

   logic [31:0] c_step_ff;
   logic [4:0]  c_x_ff, c_y_ff;
   logic        c_gate_ff, c_note_on_ff, c_accent_ff;
   logic [7:0]  c_strength_ff, c_reg_ff;

   logic        rsp_valid_ff;
   logic [31:0] rsp_step_ff;
   logic [4:0]  rsp_x_ff, rsp_y_ff;
   logic [7:0]  rsp_note_ff, rsp_strength_ff, rsp_reg_ff;
   logic        rsp_gate_ff, rsp_note_on_ff, rsp_accent_ff;

   logic          accept;
   logic [7:0]    grad;
   logic [2:0]    level;
   logic signed [4:0] level_b;
   logic [2:0]    level_c;
   logic [MaskW-1:0] mask_w;
   logic          out_free;
   logic          take;
   snap_stat_type snap_stat;
   logic [7:0]    snap_note;

   assign accept    = req_valid & ~req_stall;
   assign req_stall = ~snap_stat.idle;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign take      = snap_stat.done & out_free;

   always_comb begin
      if (!last_valid_ff) begin
         grad = 8'd0;
      end else if (req_raw_value >= last_raw_ff) begin
         grad = req_raw_value - last_raw_ff;
      end else begin
         grad = last_raw_ff - req_raw_value;
      end
   end

   // hysteresis gate, turn-on held back on odd ticks under rhythm lock
   always_comb begin
      gate_in = gate_ff;
      if (!gate_ff && grad > gate_on_ff) begin
         if (!lock_ff || !step_ff[0]) begin
            gate_in = 1'b1;
         end
      end else if (gate_ff && grad < gate_off_ff) begin
         gate_in = 1'b0;
      end
   end

   always_comb begin
      if (req_regularity > LEVEL4_LIMIT) begin
         level = 3'd4;
      end else if (req_regularity > LEVEL3_LIMIT) begin
         level = 3'd3;
      end else if (req_regularity > LEVEL2_LIMIT) begin
         level = 3'd2;
      end else if (req_regularity > LEVEL1_LIMIT) begin
         level = 3'd1;
      end else begin
         level = 3'd0;
      end
      level_b = $signed({2'b00, level}) + $signed({bias_ff[3], bias_ff});
      if (level_b < 5'sd0) begin
         level_c = 3'd0;
      end else if (level_b > 5'sd4) begin
         level_c = 3'd4;
      end else begin
         level_c = level_b[2:0];
      end
      mask_w = scale_mask(level_c);
   end

   ggsq_snap u_snap (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .depth  (req_depth_feature),
      .mask   (mask_w),
      .octave (octave_ff),
      .root   (root_ff),
      .take   (take),
      .stat   (snap_stat),
      .note   (snap_note)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff       <= 7'd36;
         octave_ff     <= 4'd3;
         gate_on_ff    <= 8'd24;
         gate_off_ff   <= 8'd8;
         accent_thr_ff <= 8'd96;
         lock_ff       <= 1'b0;
         bias_ff       <= 4'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROOT_NOTE:   root_ff       <= csr_wdata[6:0];
            CSR_OCTAVE_SPAN: octave_ff     <= csr_wdata[3:0];
            CSR_GATE_ON:     gate_on_ff    <= csr_wdata;
            CSR_GATE_OFF:    gate_off_ff   <= csr_wdata;
            CSR_ACCENT:      accent_thr_ff <= csr_wdata;
            CSR_RHYTHM_LOCK: lock_ff       <= csr_wdata[0];
            CSR_LEVEL_SHIFT: bias_ff       <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ff       <= 1'b0;
         last_raw_ff   <= 8'd0;
         last_valid_ff <= 1'b0;
         step_ff       <= 32'd0;
      end else if (accept) begin
         gate_ff       <= gate_in;
         last_raw_ff   <= req_raw_value;
         last_valid_ff <= 1'b1;
         step_ff       <= step_ff + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         c_step_ff     <= step_ff;
         c_x_ff        <= req_pos_x;
         c_y_ff        <= req_pos_y;
         c_gate_ff     <= gate_in;
         c_note_on_ff  <= gate_in & ~gate_ff;
         c_accent_ff   <= req_strength_feature > accent_thr_ff;
         c_strength_ff <= req_strength_feature;
         c_reg_ff      <= req_regularity[RegW-1:7];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_step_ff     <= c_step_ff;
         rsp_x_ff        <= c_x_ff;
         rsp_y_ff        <= c_y_ff;
         rsp_note_ff     <= snap_note;
         rsp_gate_ff     <= c_gate_ff;
         rsp_note_on_ff  <= c_note_on_ff;
         rsp_accent_ff   <= c_accent_ff;
         rsp_strength_ff <= c_strength_ff;
         rsp_reg_ff      <= c_reg_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_step_count     = rsp_step_ff;
   assign rsp_out_x          = rsp_x_ff;
   assign rsp_out_y          = rsp_y_ff;
   assign rsp_note           = rsp_note_ff;
   assign rsp_gate_out       = rsp_gate_ff;
   assign rsp_note_on        = rsp_note_on_ff;
   assign rsp_accent         = rsp_accent_ff;
   assign rsp_strength_out   = rsp_strength_ff;
   assign rsp_regularity_out = rsp_reg_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("step unit idle right after a transaction");

   a_tick_advance: assert property (@(posedge clock) disable iff (reset)
      accept |=> step_ff == $past(step_ff) + 32'd1)
      else $error("tick counter did not advance");

   a_note_on_gate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_note_on_ff && !rsp_gate_ff))
      else $error("note_on without gate");

endmodule

// ===== hw/rtl/ggsq_snap.sv =====
module ggsq_snap
   import ggsq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [7:0]          depth,
   input  logic [MaskW-1:0]    mask,
   input  logic [3:0]          octave,
   input  logic [6:0]          root,
   input  logic                take,
   output snap_stat_type       stat,
   output logic [7:0]          note
);

   snap_state_type   state_ff, state_in;
   logic [7:0]       depth_ff, depth_in;
   logic [MaskW-1:0] mask_ff, mask_in;
   logic [SpanW-1:0] span_ff, span_in;
   logic [SpanW-1:0] pos_ff, pos_in;
   logic [SpanW-1:0] dpos_ff, dpos_in;
   logic [SpanW-1:0] upos_ff, upos_in;
   logic [3:0]       dmod_ff, dmod_in;
   logic [3:0]       umod_ff, umod_in;
   logic             dok_ff, dok_in;
   logic [3:0]       k_ff, k_in;
   logic [7:0]       note_ff, note_in;

   logic [3:0]       oct_c;
   logic [SpanW-1:0] span_w;
   logic [7:0]       mul_a;
   logic [6:0]       mul_b;
   logic [14:0]      mul_p;
   logic [3:0]       quo;
   logic [SpanW-1:0] rem_w;
   logic             d_hit, u_hit;

   // shared multiplier: depth scaling, then reciprocal for the mod 12
   assign mul_a = (state_ff == SNAP_MUL) ? depth_ff : {1'b0, pos_ff};
   assign mul_b = (state_ff == SNAP_MUL) ? (span_ff - 7'd1) : RECIP12;
   assign mul_p = 15'(mul_a) * 15'(mul_b);
   assign quo   = mul_p[12:9];
   assign rem_w = pos_ff - {quo, 3'b000} - {1'b0, quo, 2'b00};

   assign oct_c  = (octave == 4'd0) ? 4'd1 : ((octave > 4'd8) ? 4'd8 : octave);
   assign span_w = {oct_c, 3'b000} + {1'b0, oct_c, 2'b00};

   assign d_hit = dok_ff & mask_ff[dmod_ff];
   assign u_hit = (upos_ff < span_ff) & mask_ff[umod_ff];

   always_comb begin
      state_in = state_ff;
      depth_in = depth_ff;
      mask_in  = mask_ff;
      span_in  = span_ff;
      pos_in   = pos_ff;
      dpos_in  = dpos_ff;
      upos_in  = upos_ff;
      dmod_in  = dmod_ff;
      umod_in  = umod_ff;
      dok_in   = dok_ff;
      k_in     = k_ff;
      note_in  = note_ff;
      case (state_ff)
         SNAP_IDLE: begin
            if (start) begin
               depth_in = depth;
               mask_in  = mask;
               span_in  = span_w;
               state_in = SNAP_MUL;
            end
         end
         SNAP_MUL: begin
            pos_in   = mul_p[14:8];
            state_in = SNAP_MOD;
         end
         SNAP_MOD: begin
            dpos_in  = pos_ff;
            upos_in  = pos_ff;
            dmod_in  = rem_w[3:0];
            umod_in  = rem_w[3:0];
            dok_in   = 1'b1;
            k_in     = 4'd0;
            state_in = SNAP_SEARCH;
         end
         SNAP_SEARCH: begin
            if (d_hit) begin
               note_in  = {1'b0, root} + {1'b0, dpos_ff};
               state_in = SNAP_DONE;
            end else if (u_hit) begin
               note_in  = {1'b0, root} + {1'b0, upos_ff};
               state_in = SNAP_DONE;
            end else if (k_ff == LAST_SEMITONE) begin
               note_in  = {1'b0, root} + {1'b0, pos_ff};
               state_in = SNAP_DONE;
            end else begin
               k_in    = k_ff + 4'd1;
               upos_in = upos_ff + 7'd1;
               umod_in = (umod_ff == LAST_SEMITONE) ? 4'd0 : umod_ff + 4'd1;
               if (dpos_ff == 7'd0) begin
                  dok_in = 1'b0;
               end else begin
                  dpos_in = dpos_ff - 7'd1;
               end
               dmod_in = (dmod_ff == 4'd0) ? SEMITONES - 4'd1 : dmod_ff - 4'd1;
            end
         end
         SNAP_DONE: begin
            if (take) begin
               state_in = SNAP_IDLE;
            end
         end
         default: state_in = SNAP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SNAP_IDLE;
      end else begin
         state_ff <= state_in;
      end
      depth_ff <= depth_in;
      mask_ff  <= mask_in;
      span_ff  <= span_in;
      pos_ff   <= pos_in;
      dpos_ff  <= dpos_in;
      upos_ff  <= upos_in;
      dmod_ff  <= dmod_in;
      umod_ff  <= umod_in;
      dok_ff   <= dok_in;
      k_ff     <= k_in;
      note_ff  <= note_in;
   end

   assign stat.idle = (state_ff == SNAP_IDLE);
   assign stat.done = (state_ff == SNAP_DONE);
   assign note      = note_ff;

endmodule
